// File: hw/rtl/trle_pkg.sv
package trle_pkg;

  // run counter width and default run limit
  localparam int RUN_W       = 8;
  localparam int MAX_RUN_DEF = 255;

  // literal store: two banks of 2**RUN_W pixels
  localparam int STORE_AW = RUN_W + 1;

  // word index inside one job: header, up to 2**RUN_W - 1 literals, second header
  localparam int IDX_W = RUN_W + 1;

  // depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // words per output beat
  localparam int BEAT_WORDS = 4;

  typedef struct packed {
    logic [15:0] pixel;
    logic        last_pixel;
  } pixel_item_t;

  typedef struct packed {
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] word2;
    logic [15:0] word3;
    logic [2:0]  word_count;
    logic        last_beat;
  } word_beat_t;

  // one emitted segment, optionally followed by a header-only segment
  typedef struct packed {
    logic [15:0]      hdr_a;
    logic [RUN_W-1:0] lit_cnt;
    logic             bank;
    logic             has_b;
    logic [15:0]      hdr_b;
  } seg_job_t;

  // literal store write from the front
  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [15:0]         data;
  } store_wr_t;

  // bank handed back once all its literals are read
  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

  function automatic logic [15:0] seg_header(input logic [RUN_W-1:0] trans_cnt,
                                             input logic [RUN_W-1:0] lit_cnt);
    seg_header = {trans_cnt, lit_cnt};
  endfunction

endpackage

// File: hw/rtl/trle_front.sv
module trle_front import trle_pkg::*; #(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        push,
  input  pixel_item_t pixel_item,
  output logic        full,
  input  logic        q_full,
  output logic        job_push,
  output seg_job_t    job,
  output store_wr_t   store_wr,
  input  bank_rel_t   rel
);

  localparam logic [RUN_W:0] MaxRun = (RUN_W + 1)'(MAX_RUN);

  logic [15:0]      key_color;
  logic             lit_phase;
  logic [RUN_W-1:0] trun;
  logic [RUN_W-1:0] lrun;
  logic             cur_bank;
  logic [1:0]       busy;
  logic [1:0]       busy_next;

  logic             lit_phase_next;
  logic [RUN_W-1:0] trun_next;
  logic [RUN_W-1:0] lrun_next;
  logic [RUN_W:0]   lrun_inc;
  logic             is_key;
  logic             accept;
  logic             emit_a;
  logic [15:0]      hdr_a;
  logic [RUN_W-1:0] cnt_a;
  logic             has_b;
  logic [15:0]      hdr_b;
  logic             wr_en;
  logic [RUN_W-1:0] wr_addr;

  // hold off while the queue is full or the open bank is still being read
  assign full   = q_full || busy[cur_bank];
  assign accept = push && !full;
  assign is_key = (pixel_item.pixel == key_color);

  // classify the pixel and decide which segments close
  always_comb begin
    lit_phase_next = lit_phase;
    trun_next      = trun;
    lrun_next      = lrun;
    lrun_inc       = {1'b0, lrun} + (RUN_W + 1)'(1);
    emit_a         = 1'b0;
    hdr_a          = '0;
    cnt_a          = '0;
    has_b          = 1'b0;
    hdr_b          = '0;
    wr_en          = 1'b0;
    wr_addr        = lrun;

    if (!lit_phase) begin
      if (is_key) begin
        if ({1'b0, trun} < MaxRun) begin
          trun_next = trun + RUN_W'(1);
        end else begin
          emit_a    = 1'b1;
          hdr_a     = seg_header(trun, '0);
          trun_next = RUN_W'(1);
        end
      end else begin
        wr_en          = 1'b1;
        wr_addr        = '0;
        lit_phase_next = 1'b1;
        lrun_next      = RUN_W'(1);
        if (MaxRun <= (RUN_W + 1)'(1)) begin
          emit_a         = 1'b1;
          hdr_a          = seg_header(trun, RUN_W'(1));
          cnt_a          = RUN_W'(1);
          lit_phase_next = 1'b0;
          trun_next      = '0;
          lrun_next      = '0;
        end
      end
    end else begin
      if (is_key) begin
        emit_a         = 1'b1;
        hdr_a          = seg_header(trun, lrun);
        cnt_a          = lrun;
        lit_phase_next = 1'b0;
        trun_next      = RUN_W'(1);
        lrun_next      = '0;
      end else begin
        wr_en     = 1'b1;
        lrun_next = lrun_inc[RUN_W-1:0];
        if (lrun_inc >= MaxRun) begin
          emit_a         = 1'b1;
          hdr_a          = seg_header(trun, lrun_inc[RUN_W-1:0]);
          cnt_a          = lrun_inc[RUN_W-1:0];
          lit_phase_next = 1'b0;
          trun_next      = '0;
          lrun_next      = '0;
        end
      end
    end

    // final pixel flushes whatever segment is still open
    if (pixel_item.last_pixel &&
        (trun_next != '0 || lrun_next != '0 || lit_phase_next)) begin
      if (emit_a) begin
        has_b = 1'b1;
        hdr_b = seg_header(trun_next, lrun_next);
      end else begin
        emit_a = 1'b1;
        hdr_a  = seg_header(trun_next, lrun_next);
        cnt_a  = lrun_next;
      end
      lit_phase_next = 1'b0;
      trun_next      = '0;
      lrun_next      = '0;
    end
  end

  assign job_push      = accept && emit_a;
  assign job.hdr_a     = hdr_a;
  assign job.lit_cnt   = cnt_a;
  assign job.bank      = cur_bank;
  assign job.has_b     = has_b;
  assign job.hdr_b     = hdr_b;
  assign store_wr.en   = accept && wr_en;
  assign store_wr.addr = {cur_bank, wr_addr};
  assign store_wr.data = pixel_item.pixel;

  // bank ownership: set when a segment with literals is queued, cleared by the back
  always_comb begin
    busy_next = busy;
    if (rel.en) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (job_push && cnt_a != '0) begin
      busy_next[cur_bank] = 1'b1;
    end
  end

  // key register and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      key_color <= '0;
      lit_phase <= 1'b0;
      trun      <= '0;
      lrun      <= '0;
      cur_bank  <= 1'b0;
      busy      <= '0;
    end else begin
      if (cfg_we) begin
        key_color <= cfg_data;
      end
      if (accept) begin
        lit_phase <= lit_phase_next;
        trun      <= trun_next;
        lrun      <= lrun_next;
      end
      if (job_push && cnt_a != '0) begin
        cur_bank <= ~cur_bank;
      end
      busy <= busy_next;
    end
  end

endmodule

// File: hw/rtl/trle_queue.sv
module trle_queue import trle_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  seg_job_t push_data,
  output logic     full,
  input  logic     pop,
  output seg_job_t pop_data,
  output logic     empty
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  seg_job_t        slots [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == CntW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hw/rtl/trle_back.sv
module trle_back import trle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  store_wr_t  store_wr,
  input  logic       job_empty,
  input  seg_job_t   job,
  output logic       job_pop,
  output bank_rel_t  rel,
  output word_beat_t word_beat,
  output logic       empty,
  input  logic       pop
);

  logic [15:0] store [2**STORE_AW];

  logic             active;
  seg_job_t         cur_job;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] last_idx;

  logic             s2_valid;
  logic             s2_from_mem;
  logic [15:0]      s2_hdr;
  logic             s2_last;
  logic [15:0]      rd_data;

  logic [15:0]      pack [BEAT_WORDS];
  logic [1:0]       pack_cnt;

  logic             out_valid;
  word_beat_t       out_beat;

  logic             out_free;
  logic [15:0]      s2_word;
  logic             s2_close;
  logic             adv;
  logic             issue;
  logic             is_mem;
  logic             idx_last;
  logic [15:0]      hdr_sel;
  logic [RUN_W-1:0] idx_m1;
  logic [15:0]      slot [BEAT_WORDS];
  word_beat_t       beat;

  assign out_free = !out_valid || pop;
  assign s2_word  = s2_from_mem ? rd_data : s2_hdr;
  assign s2_close = s2_last || (pack_cnt == 2'd3);
  assign adv      = !(s2_valid && s2_close && !out_free);
  assign job_pop  = !active && !job_empty;
  assign issue    = active && adv;

  // word select for the current index: header, literal, trailing header
  assign idx_m1   = idx[RUN_W-1:0] - RUN_W'(1);
  assign is_mem   = (idx != '0) && (idx <= {1'b0, cur_job.lit_cnt});
  assign hdr_sel  = (idx == '0) ? cur_job.hdr_a : cur_job.hdr_b;
  assign idx_last = (idx == last_idx);

  assign rel.en   = issue && idx_last && (cur_job.lit_cnt != '0);
  assign rel.bank = cur_job.bank;

  // assemble a beat from the packed words and the incoming one
  always_comb begin
    for (int j = 0; j < BEAT_WORDS; j++) begin
      if (j < int'(pack_cnt)) begin
        slot[j] = pack[j];
      end else if (j == int'(pack_cnt)) begin
        slot[j] = s2_word;
      end else begin
        slot[j] = '0;
      end
    end
    beat.word0      = slot[0];
    beat.word1      = slot[1];
    beat.word2      = slot[2];
    beat.word3      = slot[3];
    beat.word_count = {1'b0, pack_cnt} + 3'd1;
    beat.last_beat  = s2_last;
  end

  assign word_beat = out_beat;
  assign empty     = !out_valid;

  // literal store, two banks
  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      store[store_wr.addr] <= store_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && is_mem) begin
      rd_data <= store[{cur_job.bank, idx_m1}];
    end
  end

  // sequencer, word stage and output control
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      s2_valid  <= 1'b0;
      pack_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (job_pop) begin
        active <= 1'b1;
      end else if (issue && idx_last) begin
        active <= 1'b0;
      end
      if (adv) begin
        s2_valid <= issue;
      end
      if (adv && s2_valid) begin
        pack_cnt <= s2_close ? 2'd0 : pack_cnt + 2'd1;
      end
      if (adv && s2_valid && s2_close) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur_job  <= job;
      idx      <= '0;
      last_idx <= {1'b0, job.lit_cnt} + IDX_W'(job.has_b);
    end else if (issue) begin
      idx <= idx + IDX_W'(1);
    end
    if (adv) begin
      s2_from_mem <= is_mem;
      s2_hdr      <= hdr_sel;
      s2_last     <= idx_last;
    end
    if (adv && s2_valid && !s2_close) begin
      pack[pack_cnt] <= s2_word;
    end
    if (adv && s2_valid && s2_close) begin
      out_beat <= beat;
    end
  end

endmodule

// File: hw/rtl/transparent_run_rle_encoder_top.sv
// transparent-run / literal run-length encoder for 16-bit pixels
//
// input queue: pixel_item (pixel, last_pixel) is taken on a clock edge with
// push high and full low. output queue: word_beat holds the oldest beat while
// empty is low and leaves on an edge with pop high. cfg_we/cfg_data write the
// key color; write it only while the block is idle.
//
// each segment is a header word (transparent count << 8 | literal count)
// followed by its literal pixels, packed four words to a beat; word slots past
// word_count read zero and last_beat marks the final beat of one pixel.
//
// the front classifies one pixel per cycle and writes literals into one of two
// banks of the literal store; it stalls only when the four-entry job queue is
// full or the bank it would fill is still being read. the back takes a queued job
// only while idle and then emits its words, one word per cycle unless a full
// output register stalls it; each word passes the word stage and is packed into
// the output register, which holds the beat until it is popped.
// a stalled receiver holds the output register, then the back, then the queue.
// reset (rst, synchronous) empties both sides and sets the key color to 0.
module transparent_run_rle_encoder_top import trle_pkg::*; #(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        push,
  input  pixel_item_t pixel_item,
  output logic        full,
  input  logic        pop,
  output word_beat_t  word_beat,
  output logic        empty
);

  logic      q_full;
  logic      q_empty;
  logic      job_push;
  logic      job_pop;
  seg_job_t  job_in;
  seg_job_t  job_out;
  store_wr_t store_wr;
  bank_rel_t rel;

  // pixel classification and run counting
  trle_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .push       (push),
    .pixel_item (pixel_item),
    .full       (full),
    .q_full     (q_full),
    .job_push   (job_push),
    .job        (job_in),
    .store_wr   (store_wr),
    .rel        (rel)
  );

  // segment jobs waiting for the back
  trle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .full      (q_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (q_empty)
  );

  // word generation and beat packing
  trle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .store_wr  (store_wr),
    .job_empty (q_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .rel       (rel),
    .word_beat (word_beat),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// File: hw/rtl/trle_checker.sv
module trle_checker import trle_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       pop,
  input logic       empty,
  input word_beat_t word_beat
);

  // output side is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // a shown beat carries one to four words
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (word_beat.word_count != 3'd0 && word_beat.word_count <= 3'd4))
    else $error("word_count out of range");

  // slots past word_count are zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((word_beat.word_count >= 3'd2 || word_beat.word1 == 16'd0) &&
                (word_beat.word_count >= 3'd3 || word_beat.word2 == 16'd0) &&
                (word_beat.word_count == 3'd4 || word_beat.word3 == 16'd0)))
    else $error("unused word slot not zero");

  // a beat not taken stays in place
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(word_beat)))
    else $error("stalled beat changed");

endmodule

bind transparent_run_rle_encoder_top trle_checker u_trle_checker (
  .clk       (clk),
  .rst       (rst),
  .pop       (pop),
  .empty     (empty),
  .word_beat (word_beat)
);

// File: test/tb_top.sv
module tb_top;
  import trle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT   = MAX_RUN_DEF;
  localparam int MAX_BEATS   = 64;
  localparam int SETTLE_CYC  = 16;
  localparam int TAIL_CYC    = 40;
  localparam int CYCLE_LIMIT = 2000000;

  typedef logic [15:0] word_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_data;
  logic        push;
  pixel_item_t pixel_item;
  logic        full;
  logic        pop = 1'b0;
  word_beat_t  word_beat;
  logic        empty;

  // idle percentages for the two sides
  int unsigned send_gap_pct;
  int unsigned recv_gap_pct;

  // encoder shadow state
  logic [15:0] key_shadow;
  logic        in_lit;
  int unsigned trans_cnt;
  int unsigned lit_cnt;
  word_t       lit_shadow [256];
  word_t       seg_words [$];

  // beats still owed by the block, oldest first
  word_beat_t  beats_due [$];

  int unsigned errors = 0;
  int unsigned pixels_sent;
  int unsigned beats_seen = 0;
  int unsigned key_writes;
  int unsigned cycles = 0;

  transparent_run_rle_encoder_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .push       (push),
    .pixel_item (pixel_item),
    .full       (full),
    .pop        (pop),
    .word_beat  (word_beat),
    .empty      (empty)
  );

  always #6 clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL transparent_run_rle_encoder_top");
      $finish;
    end
  end

  // receiver side: random pop stalls
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // close the open segment: header then its literals
  function automatic void close_segment();
    seg_words.push_back({trans_cnt[7:0], lit_cnt[7:0]});
    for (int i = 0; i < lit_cnt; i++) seg_words.push_back(lit_shadow[i]);
    trans_cnt = 0;
    lit_cnt   = 0;
    in_lit    = 1'b0;
  endfunction

  // advance the shadow encoder by one pixel and queue the beats it causes
  function automatic void predict_encode(input pixel_item_t it);
    word_beat_t  b;
    word_t       slot [4];
    int          n_beats;
    int          k;
    int unsigned cnt;
    logic        hit;
    hit = (it.pixel == key_shadow);
    seg_words.delete();
    if (!in_lit) begin
      if (hit) begin
        if (trans_cnt < RUN_LIMIT) trans_cnt++;
        else begin
          close_segment();
          trans_cnt = 1;
        end
      end else begin
        in_lit        = 1'b1;
        lit_shadow[0] = it.pixel;
        lit_cnt       = 1;
        if (lit_cnt >= RUN_LIMIT) close_segment();
      end
    end else if (hit) begin
      close_segment();
      trans_cnt = 1;
    end else begin
      lit_shadow[lit_cnt[7:0]] = it.pixel;
      lit_cnt++;
      if (lit_cnt >= RUN_LIMIT) close_segment();
    end
    // final pixel flushes whatever is open
    if (it.last_pixel && (trans_cnt != 0 || lit_cnt != 0 || in_lit)) close_segment();
    // pack four words per beat
    n_beats = (seg_words.size() + 3) / 4;
    if (n_beats > MAX_BEATS) n_beats = MAX_BEATS;
    for (int bi = 0; bi < n_beats; bi++) begin
      k   = bi * 4;
      cnt = 0;
      for (int j = 0; j < 4; j++) begin
        if (k + j < seg_words.size()) begin
          slot[j] = seg_words[k + j];
          cnt++;
        end else begin
          slot[j] = '0;
        end
      end
      b            = '0;
      b.word0      = slot[0];
      b.word1      = slot[1];
      b.word2      = slot[2];
      b.word3      = slot[3];
      b.word_count = cnt[2:0];
      b.last_beat  = (bi == n_beats - 1);
      beats_due.push_back(b);
    end
  endfunction

  // output checker: a beat moves on the edge after this sample
  always @(negedge clk) begin : beat_check
    word_beat_t want;
    if (!rst && pop && !empty) begin
      if (beats_due.size() == 0) begin
        $error("beat with nothing expected: %h", word_beat);
        errors++;
      end else begin
        want = beats_due.pop_front();
        beats_seen++;
        if (word_beat.word0 !== want.word0) begin
          $error("word0 expected %h actual %h", want.word0, word_beat.word0);
          errors++;
        end
        if (word_beat.word1 !== want.word1) begin
          $error("word1 expected %h actual %h", want.word1, word_beat.word1);
          errors++;
        end
        if (word_beat.word2 !== want.word2) begin
          $error("word2 expected %h actual %h", want.word2, word_beat.word2);
          errors++;
        end
        if (word_beat.word3 !== want.word3) begin
          $error("word3 expected %h actual %h", want.word3, word_beat.word3);
          errors++;
        end
        if (word_beat.word_count !== want.word_count) begin
          $error("word_count expected %0d actual %0d", want.word_count,
                 word_beat.word_count);
          errors++;
        end
        if (word_beat.last_beat !== want.last_beat) begin
          $error("last_beat expected %0d actual %0d", want.last_beat,
                 word_beat.last_beat);
          errors++;
        end
      end
    end
  end

  // send one pixel beat, with random idle cycles ahead of it
  task automatic send_pixel(input logic [15:0] pix, input logic last);
    pixel_item_t it;
    logic        took;
    it.pixel      = pix;
    it.last_pixel = last;
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    pixel_item <= it;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = !full;
      @(posedge clk);
    end
    predict_encode(it);
    pixels_sent++;
  endtask

  // stop sending until every owed beat has come out
  task automatic hold_until_drained();
    push <= 1'b0;
    @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
  endtask

  // key color write with the block idle
  task automatic write_key(input logic [15:0] k);
    hold_until_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= k;
    @(posedge clk);
    cfg_we   <= 1'b0;
    key_shadow = k;
    key_writes++;
  endtask

  // any pixel except the key
  function automatic logic [15:0] other_than_key(input logic [15:0] p);
    if (p == key_shadow) return p ^ (16'h1 << $urandom_range(15));
    return p;
  endfunction

  // mostly short runs, now and then one around the run limit
  function automatic int pick_run_len();
    int r;
    r = $urandom_range(99);
    if (r < 4) return $urandom_range(RUN_LIMIT + 3, RUN_LIMIT - 3);
    if (r < 12) return $urandom_range(40, 7);
    return $urandom_range(6, 1);
  endfunction

  // reset key of zero, byte extremes, key in literal phase, lone flushes
  task automatic test_reset_key();
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h00FF, 1'b0);
    send_pixel(16'hFF00, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h8001, 1'b0);
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'h7FFE, 1'b1);
    send_pixel(16'h0000, 1'b1);
  endtask

  // key compared on all 16 bits, low byte included
  task automatic test_key_low_byte();
    write_key(16'h00FF);
    send_pixel(16'h00FF, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h01FF, 1'b0);
    send_pixel(16'h00FE, 1'b0);
    send_pixel(16'h00FF, 1'b0);
    send_pixel(16'hFF00, 1'b0);
    send_pixel(16'h00FF, 1'b1);
  endtask

  // literal run hitting the limit, and the widest single-pixel output
  task automatic test_literal_limit();
    write_key(16'hFFFF);
    // limit reached on the final pixel: nothing left to flush
    for (int i = 0; i < RUN_LIMIT; i++) send_pixel(16'(i * 257), i == RUN_LIMIT - 1);
    // one short of the limit, then key with last: header, 254 literals, header
    repeat (3) send_pixel(16'hFFFF, 1'b0);
    for (int i = 0; i < RUN_LIMIT - 1; i++) send_pixel(16'($urandom) & 16'h7FFF, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
  endtask

  // transparent run hitting the limit
  task automatic test_transparent_limit();
    write_key(16'h1234);
    // key after a full run with last: two segments at once
    repeat (RUN_LIMIT) send_pixel(16'h1234, 1'b0);
    send_pixel(16'h1234, 1'b1);
  endtask

  // key runs then literal runs, with noise and a mid-stream drain
  task automatic test_random_traffic(input int n_items);
    int          sent;
    int          run;
    int          kind;
    logic [15:0] pix;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 78) begin
        run = pick_run_len();
        repeat (run) begin
          send_pixel(key_shadow, $urandom_range(39) == 0);
          sent++;
        end
        run = pick_run_len();
        repeat (run) begin
          send_pixel(other_than_key(16'($urandom)), $urandom_range(39) == 0);
          sent++;
        end
      end else if (kind < 96) begin
        case ($urandom_range(2))
          0: pix = 16'($urandom);
          1: pix = key_shadow ^ (16'h1 << $urandom_range(15));
          default: pix = {key_shadow[7:0], key_shadow[15:8]};
        endcase
        send_pixel(pix, $urandom_range(7) == 0);
        sent++;
      end else begin
        hold_until_drained();
      end
    end
    send_pixel(16'($urandom), 1'b1);
  endtask

  initial begin
    rst          = 1'b1;
    push         = 1'b0;
    pixel_item   = '0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    send_gap_pct = 13;
    recv_gap_pct = 74;
    pixels_sent  = 0;
    key_writes   = 0;
    key_shadow   = '0;
    in_lit       = 1'b0;
    trans_cnt    = 0;
    lit_cnt      = 0;
    foreach (lit_shadow[i]) lit_shadow[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_key();
    test_key_low_byte();
    test_literal_limit();
    test_transparent_limit();

    write_key(16'($urandom));
    test_random_traffic(60);

    send_gap_pct = 74;
    recv_gap_pct = 13;
    write_key(16'h0000);
    test_random_traffic(60);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_key(16'($urandom));
    test_random_traffic(40);
    write_key(16'hFFFF);
    test_random_traffic(40);

    // drain, then give the block time to show any stray beat
    hold_until_drained();
    repeat (TAIL_CYC) @(posedge clk);
    if (beats_due.size() != 0) begin
      $error("%0d beats never arrived", beats_due.size());
    end

    $display("covered %0d pixels and %0d output beats over %0d key color settings",
             pixels_sent, beats_seen, key_writes);
    $display("run limits on both run kinds, low-byte keys, idle mixes on either side and none");
    if (errors == 0 && beats_due.size() == 0) begin
      $display("PASS transparent_run_rle_encoder_top");
    end else begin
      $display("FAIL transparent_run_rle_encoder_top");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/trle_pkg.sv
hw/rtl/trle_front.sv
hw/rtl/trle_queue.sv
hw/rtl/trle_back.sv
hw/rtl/transparent_run_rle_encoder_top.sv
hw/rtl/trle_checker.sv
test/tb_top.sv
